### rtl/core/pbwf_pkg.sv
// shared types and constants for the protobuf wire field decoder
`default_nettype none
package pbwf_pkg;

	// largest accepted length-delimited payload
	localparam int MAX_STRING_LEN = 65535;
	localparam int LEN_W = $clog2(MAX_STRING_LEN + 1);

	// record queue between parser and output stage, power of two
	localparam int FIFO_DEPTH = 4;

	localparam int FIELD_W = 29;

	localparam logic [1:0] KIND_SCALAR = 2'd0;
	localparam logic [1:0] KIND_STR_HDR = 2'd1;
	localparam logic [1:0] KIND_STR_BYTE = 2'd2;
	localparam logic [1:0] KIND_END = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TRUNC = 2'd1;
	localparam logic [1:0] ST_BAD_TAG = 2'd2;
	localparam logic [1:0] ST_OVERSIZE = 2'd3;

	localparam logic [2:0] WIRE_VARINT = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LEN = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} pbwf_in_t;

	typedef struct packed {
		logic [1:0]         record_kind;
		logic [FIELD_W-1:0] field_number;
		logic [2:0]         wire_type;
		logic [63:0]        value;
		logic               last_record;
		logic [1:0]         status;
	} pbwf_out_t;

	// record between parser and output stage, zigzag still pending
	typedef struct packed {
		pbwf_out_t rec;
		logic      zigzag;
	} pbwf_rec_t;

endpackage
`default_nettype wire

### rtl/core/pbwf_parse.sv
// front end: byte-wise tag, varint, fixed and length parsing into records
`default_nettype none
module pbwf_parse
	import pbwf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire pbwf_in_t           item,
	input  wire logic [FIELD_W-1:0] signed_field_a,
	input  wire logic [FIELD_W-1:0] signed_field_b,
	output logic                    rec_valid,
	output pbwf_rec_t               rec
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_VAR,
		PH_F64,
		PH_F32,
		PH_LEN,
		PH_PAY,
		PH_DROP
	} phase_t;

	phase_t             phase_q, n_phase;
	logic [63:0]        acc_q, n_acc;
	logic [6:0]         shift_q, n_shift;
	logic [FIELD_W-1:0] field_q, n_field;
	logic [2:0]         wire_q, n_wire;
	logic [LEN_W-1:0]   left_q, n_left, left_dec;
	logic [1:0]         err_q, n_err;

	logic [7:0]  b;
	logic [63:0] var_acc, fix_acc;
	logic        overlong, fix_done;
	logic        emit;
	logic [1:0]  kind;
	logic [63:0] val;

	assign b = item.data_byte;
	assign var_acc = acc_q | (64'(b[6:0]) << shift_q[5:0]);
	assign fix_acc = acc_q | (64'(b) << shift_q[5:0]);
	// continuation past the tenth byte
	assign overlong = b[7] && (shift_q > 7'd56);
	assign fix_done = shift_q >= ((phase_q == PH_F64) ? 7'd56 : 7'd24);
	assign left_dec = (left_q != '0) ? left_q - LEN_W'(1) : left_q;

	always_comb begin
		n_phase = phase_q;
		n_acc = acc_q;
		n_shift = shift_q;
		n_field = field_q;
		n_wire = wire_q;
		n_left = left_q;
		n_err = err_q;
		emit = 1'b0;
		kind = KIND_SCALAR;
		val = '0;

		case (phase_q)
			PH_TAG, PH_VAR, PH_LEN: begin
				if (!b[7]) begin
					n_acc = '0;
					n_shift = '0;
					case (phase_q)
						PH_TAG: begin
							if (var_acc == '0 || var_acc[63:32] != '0) begin
								n_err = ST_BAD_TAG;
								n_phase = PH_DROP;
							end else begin
								n_field = var_acc[FIELD_W+2:3];
								n_wire = var_acc[2:0];
								case (var_acc[2:0])
									WIRE_VARINT: n_phase = PH_VAR;
									WIRE_FIXED64: n_phase = PH_F64;
									WIRE_LEN: n_phase = PH_LEN;
									WIRE_FIXED32: n_phase = PH_F32;
									default: begin
										n_err = ST_BAD_TAG;
										n_phase = PH_DROP;
									end
								endcase
							end
						end
						PH_VAR: begin
							emit = 1'b1;
							val = var_acc;
							n_phase = PH_TAG;
						end
						default: begin
							if (var_acc > 64'(MAX_STRING_LEN)) begin
								n_err = ST_OVERSIZE;
								n_phase = PH_DROP;
							end else begin
								emit = 1'b1;
								kind = KIND_STR_HDR;
								val = var_acc;
								n_left = var_acc[LEN_W-1:0];
								n_phase = (var_acc[LEN_W-1:0] != '0) ? PH_PAY : PH_TAG;
							end
						end
					endcase
				end else if (overlong) begin
					n_err = ST_OVERSIZE;
					n_phase = PH_DROP;
					n_acc = '0;
					n_shift = '0;
				end else begin
					n_acc = var_acc;
					n_shift = shift_q + 7'd7;
				end
			end
			PH_F64, PH_F32: begin
				if (fix_done) begin
					emit = 1'b1;
					val = fix_acc;
					n_acc = '0;
					n_shift = '0;
					n_phase = PH_TAG;
				end else begin
					n_acc = fix_acc;
					n_shift = shift_q + 7'd8;
				end
			end
			PH_PAY: begin
				emit = 1'b1;
				kind = KIND_STR_BYTE;
				val = 64'(b);
				n_left = left_dec;
				if (left_dec == '0) begin
					n_phase = PH_TAG;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rec.rec.record_kind = kind;
		rec.rec.field_number = field_q;
		rec.rec.wire_type = wire_q;
		rec.rec.value = val;
		rec.rec.last_record = 1'b0;
		rec.rec.status = ST_OK;
		rec.zigzag = (phase_q == PH_VAR) &&
			(field_q == signed_field_a || field_q == signed_field_b);
		if (item.end_of_message) begin
			rec.rec.last_record = 1'b1;
			if (n_err != ST_OK) begin
				rec.rec.status = n_err;
			end else if (n_phase != PH_TAG) begin
				rec.rec.status = ST_TRUNC;
			end
			if (!emit) begin
				rec.rec.record_kind = KIND_END;
				rec.rec.field_number = '0;
				rec.rec.wire_type = '0;
				rec.rec.value = '0;
				rec.zigzag = 1'b0;
			end
		end
		rec_valid = accept && (emit || item.end_of_message);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q <= '0;
			shift_q <= '0;
			field_q <= '0;
			wire_q <= '0;
			left_q <= '0;
			err_q <= ST_OK;
		end else if (accept) begin
			if (item.end_of_message) begin
				// message closed, start fresh
				phase_q <= PH_TAG;
				acc_q <= '0;
				shift_q <= '0;
				field_q <= '0;
				wire_q <= '0;
				left_q <= '0;
				err_q <= ST_OK;
			end else begin
				phase_q <= n_phase;
				acc_q <= n_acc;
				shift_q <= n_shift;
				field_q <= n_field;
				wire_q <= n_wire;
				left_q <= n_left;
				err_q <= n_err;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/pbwf_fifo.sv
// short record queue between the parser and the output stage
`default_nettype none
module pbwf_fifo
	import pbwf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire pbwf_rec_t wr_data,
	input  wire logic      rd_en,
	output pbwf_rec_t      rd_data,
	output logic           full,
	output logic           not_empty
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	pbwf_rec_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full = cnt_q == (PTR_W + 1)'(FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (PTR_W + 1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (PTR_W + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/pbwf_emit.sv
// back end: zigzag decode and output register
`default_nettype none
module pbwf_emit
	import pbwf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      rec_avail,
	input  wire pbwf_rec_t rec,
	output logic           rec_take,
	input  wire logic      pop,
	output logic           empty,
	output pbwf_out_t      result
);

	logic      valid_q;
	pbwf_out_t out_q;
	pbwf_out_t decoded;

	always_comb begin
		decoded = rec.rec;
		if (rec.zigzag) begin
			decoded.value = (rec.rec.value >> 1) ^ {64{rec.rec.value[0]}};
		end
	end

	assign rec_take = rec_avail && (!valid_q || pop);
	assign empty = !valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (rec_take) begin
			out_q <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/core/protobuf_wire_field_decoder.sv
// protobuf wire field decoder: one message byte per cycle in, one record per cycle out
// while the record queue has room and the receiver pops; the result is registered
// throughput: one byte per cycle unless the queue is full, set by the per-byte parse update
// records pass through a four-entry queue and an output register
// reset: parser back to expecting a tag, queue and output register empty, zigzag fields at 3 and 9
`default_nettype none
module protobuf_wire_field_decoder
	import pbwf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire pbwf_in_t    item,
	output logic             empty,
	input  wire logic        pop,
	output pbwf_out_t        result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [FIELD_W-1:0] sfa_q, sfb_q;
	logic               cfg_wr;
	logic               accept;
	logic               rec_valid;
	pbwf_rec_t          rec_in, rec_out;
	logic               fifo_not_empty, rec_take;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? 32'(sfb_q) : 32'(sfa_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfa_q <= FIELD_W'(3);
			sfb_q <= FIELD_W'(9);
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				sfb_q <= pwdata[FIELD_W-1:0];
			end else begin
				sfa_q <= pwdata[FIELD_W-1:0];
			end
		end
	end

	assign accept = push && !full;

	pbwf_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.item           (item),
		.signed_field_a (sfa_q),
		.signed_field_b (sfb_q),
		.rec_valid      (rec_valid),
		.rec            (rec_in)
	);

	pbwf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (rec_valid),
		.wr_data   (rec_in),
		.rd_en     (rec_take),
		.rd_data   (rec_out),
		.full      (full),
		.not_empty (fifo_not_empty)
	);

	pbwf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_avail (fifo_not_empty),
		.rec       (rec_out),
		.rec_take  (rec_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
`default_nettype wire

### tb/sv/protobuf_wire_field_decoder_tb.sv
// testbench for the protobuf wire field decoder: directed and random messages checked by a predictor
`default_nettype none
module protobuf_wire_field_decoder_tb;
	import pbwf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned IDLE_PERCENT = 29;

	localparam logic [2:0] ADDR_SIGNED_FIELD_A = 3'd0;
	localparam logic [2:0] ADDR_SIGNED_FIELD_B = 3'd4;
	localparam logic [FIELD_W-1:0] SIGNED_A_RESET = 29'd3;
	localparam logic [FIELD_W-1:0] SIGNED_B_RESET = 29'd9;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	// wire types the decoder rejects
	localparam logic [2:0] WIRE_GROUP_START = 3'd3;
	localparam logic [2:0] WIRE_GROUP_END = 3'd4;
	localparam logic [2:0] WIRE_RESERVED_6 = 3'd6;
	localparam logic [2:0] WIRE_RESERVED_7 = 3'd7;

	typedef enum logic [2:0] {
		AT_TAG, IN_VARINT, IN_FIXED64, IN_FIXED32, IN_LENGTH, IN_PAYLOAD, DROPPING
	} parse_phase_e;

	typedef enum logic [1:0] {VARINT_MORE, VARINT_DONE, VARINT_OVERLONG} varint_step_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	pbwf_in_t    item = '0;
	logic        empty;
	logic        pop = 1'b0;
	pbwf_out_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	protobuf_wire_field_decoder u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [FIELD_W-1:0] zz_field_a;
	logic [FIELD_W-1:0] zz_field_b;
	parse_phase_e       parse_phase;
	logic [63:0]        acc_bits;
	logic [6:0]         acc_shift;
	logic [FIELD_W-1:0] field_now;
	logic [2:0]         wire_now;
	logic [LEN_W-1:0]   payload_left;
	logic [1:0]         err_status;

	pbwf_out_t          pending_records[$];
	logic [7:0]         msg_bytes[$];
	int unsigned        fail_count = 0;
	int unsigned        cycle_count = 0;
	int unsigned        bytes_sent = 0;
	bit                 idle_on = 1'b1;
	int unsigned        hold_reqs = 0;
	int unsigned        holds_done = 0;
	int unsigned        hold_left = 0;

	task automatic flag_error(input string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	function automatic void clear_parse_state();
		parse_phase = AT_TAG;
		acc_bits = '0;
		acc_shift = '0;
		field_now = '0;
		wire_now = '0;
		payload_left = '0;
		err_status = ST_OK;
	endfunction

	function automatic void parse_fail(input logic [1:0] code);
		err_status = code;
		parse_phase = DROPPING;
		acc_bits = '0;
		acc_shift = '0;
	endfunction

	function automatic varint_step_e varint_feed(input logic [7:0] b);
		if (acc_shift > 7'd63)
			return VARINT_OVERLONG;
		acc_bits |= 64'(b[6:0]) << acc_shift;
		if (!b[7])
			return VARINT_DONE;
		acc_shift += 7'd7;
		if (acc_shift > 7'd63)
			return VARINT_OVERLONG;
		return VARINT_MORE;
	endfunction

	// returns 1 when the byte yields a record
	function automatic bit decode_byte(input pbwf_in_t in, output pbwf_out_t rec);
		logic [7:0]   b;
		bit           emit;
		logic [1:0]   kind;
		logic [63:0]  val;
		logic [63:0]  tag;
		varint_step_e step;
		b = in.data_byte;
		emit = 1'b0;
		kind = KIND_SCALAR;
		val = '0;
		rec = '0;
		case (parse_phase)
		AT_TAG: begin
			step = varint_feed(b);
			if (step == VARINT_OVERLONG) begin
				parse_fail(ST_OVERSIZE);
			end else if (step == VARINT_DONE) begin
				tag = acc_bits;
				acc_bits = '0;
				acc_shift = '0;
				if (tag == 64'd0 || tag > 64'hffff_ffff) begin
					parse_fail(ST_BAD_TAG);
				end else begin
					field_now = tag[31:3];
					wire_now = tag[2:0];
					case (wire_now)
					WIRE_VARINT: parse_phase = IN_VARINT;
					WIRE_FIXED64: parse_phase = IN_FIXED64;
					WIRE_LEN: parse_phase = IN_LENGTH;
					WIRE_FIXED32: parse_phase = IN_FIXED32;
					default: parse_fail(ST_BAD_TAG);
					endcase
				end
			end
		end
		IN_VARINT: begin
			step = varint_feed(b);
			if (step == VARINT_OVERLONG) begin
				parse_fail(ST_OVERSIZE);
			end else if (step == VARINT_DONE) begin
				val = acc_bits;
				if (field_now == zz_field_a || field_now == zz_field_b)
					val = (acc_bits >> 1) ^ {64{acc_bits[0]}};
				emit = 1'b1;
				acc_bits = '0;
				acc_shift = '0;
				parse_phase = AT_TAG;
			end
		end
		IN_FIXED64, IN_FIXED32: begin
			acc_bits |= 64'(b) << acc_shift[5:0];
			if (acc_shift >= ((parse_phase == IN_FIXED64) ? 7'd56 : 7'd24)) begin
				val = acc_bits;
				emit = 1'b1;
				acc_bits = '0;
				acc_shift = '0;
				parse_phase = AT_TAG;
			end else begin
				acc_shift += 7'd8;
			end
		end
		IN_LENGTH: begin
			step = varint_feed(b);
			if (step == VARINT_OVERLONG) begin
				parse_fail(ST_OVERSIZE);
			end else if (step == VARINT_DONE) begin
				if (acc_bits > 64'(MAX_STRING_LEN)) begin
					parse_fail(ST_OVERSIZE);
				end else begin
					val = acc_bits;
					emit = 1'b1;
					kind = KIND_STR_HDR;
					payload_left = LEN_W'(acc_bits);
					parse_phase = (payload_left != 0) ? IN_PAYLOAD : AT_TAG;
					acc_bits = '0;
					acc_shift = '0;
				end
			end
		end
		IN_PAYLOAD: begin
			val = 64'(b);
			emit = 1'b1;
			kind = KIND_STR_BYTE;
			if (payload_left != 0)
				payload_left--;
			if (payload_left == 0)
				parse_phase = AT_TAG;
		end
		default: ;
		endcase

		if (emit) begin
			rec.record_kind = kind;
			rec.field_number = field_now;
			rec.wire_type = wire_now;
			rec.value = val;
		end
		if (in.end_of_message) begin
			rec.last_record = 1'b1;
			if (err_status != ST_OK)
				rec.status = err_status;
			else if (parse_phase != AT_TAG)
				rec.status = ST_TRUNC;
			if (!emit)
				rec.record_kind = KIND_END;
			clear_parse_state();
		end
		return emit || in.end_of_message;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// result side: compare every popped transaction with the oldest prediction
	always @(posedge clk) begin
		pbwf_out_t want;
		if (arst_n && pop && !empty) begin
			if (pending_records.size() == 0) begin
				flag_error($sformatf("record with nothing predicted: %h", result));
			end else begin
				want = pending_records.pop_front();
				compare_field("record_kind", result.record_kind, want.record_kind);
				compare_field("field_number", result.field_number, want.field_number);
				compare_field("wire_type", result.wire_type, want.wire_type);
				compare_field("value", result.value, want.value);
				compare_field("last_record", result.last_record, want.last_record);
				compare_field("status", result.status, want.status);
			end
		end
	end

	// receiver: random pop, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			pop = 1'b0;
			hold_left--;
		end else if (hold_reqs != holds_done) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
			pop = 1'b0;
		end else begin
			pop = !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic eom);
		pbwf_in_t  v;
		pbwf_out_t rec;
		v.data_byte = b;
		v.end_of_message = eom;
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			push = 1'b0;
			item = pbwf_in_t'(9'($urandom));
			@(negedge clk);
		end
		push = 1'b1;
		item = v;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (decode_byte(v, rec))
			pending_records.push_back(rec);
		bytes_sent++;
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		msg_bytes.delete();
	endtask

	function automatic void add_varint(input logic [63:0] v);
		logic [63:0] rest;
		logic [7:0]  b;
		rest = v;
		do begin
			b = {1'b0, rest[6:0]};
			rest = rest >> 7;
			if (rest != 0)
				b[7] = 1'b1;
			msg_bytes.push_back(b);
		end while (rest != 0);
	endfunction

	function automatic void add_tag(input logic [FIELD_W-1:0] fld, input logic [2:0] wt);
		add_varint({32'd0, fld, wt});
	endfunction

	function automatic void add_fixed(input logic [63:0] v, input int unsigned n);
		for (int i = 0; i < n; i++)
			msg_bytes.push_back(v[8*i +: 8]);
	endfunction

	function automatic void add_scalar(input logic [FIELD_W-1:0] fld, input logic [63:0] v);
		add_tag(fld, WIRE_VARINT);
		add_varint(v);
	endfunction

	function automatic void add_string(input logic [FIELD_W-1:0] fld, input int unsigned len);
		add_tag(fld, WIRE_LEN);
		add_varint(64'(len));
		repeat (len)
			msg_bytes.push_back(8'($urandom));
	endfunction

	function automatic void add_run(input logic [7:0] b, input int unsigned n);
		repeat (n)
			msg_bytes.push_back(b);
	endfunction

	task automatic wait_drained();
		while (pending_records.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic check_register(input logic [2:0] addr, input logic [FIELD_W-1:0] want);
		logic [31:0] data;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (data !== 32'(want))
			flag_error($sformatf("register %0d read %0h want %0h", addr, data, want));
	endtask

	task automatic set_zigzag_field(input logic [2:0] addr, input logic [31:0] data);
		wait_drained();
		cfg_write(addr, data);
		if (addr == ADDR_SIGNED_FIELD_A) begin
			zz_field_a = data[FIELD_W-1:0];
			check_register(addr, zz_field_a);
		end else begin
			zz_field_b = data[FIELD_W-1:0];
			check_register(addr, zz_field_b);
		end
	endtask

	function automatic logic [FIELD_W-1:0] pick_field();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 25)
			return zz_field_a;
		if (r < 45)
			return zz_field_b;
		if (r < 85)
			return FIELD_W'($urandom_range(1, 31));
		return FIELD_W'($urandom);
	endfunction

	function automatic logic [2:0] pick_bad_wire();
		case ($urandom_range(3))
		0: return WIRE_GROUP_START;
		1: return WIRE_GROUP_END;
		2: return WIRE_RESERVED_6;
		default: return WIRE_RESERVED_7;
		endcase
	endfunction

	// mostly well-formed fields, some corrupt ones, some cut short, some pure noise
	task automatic build_random_message();
		int unsigned        n;
		int unsigned        r;
		int unsigned        keep;
		logic [FIELD_W-1:0] fld;
		msg_bytes.delete();
		if ($urandom_range(99) < 12) begin
			repeat ($urandom_range(1, 12))
				msg_bytes.push_back(8'($urandom));
			return;
		end
		n = $urandom_range(1, 4);
		repeat (n) begin
			fld = pick_field();
			r = $urandom_range(99);
			if (r < 30) begin
				add_scalar(fld, {$urandom, $urandom} >> $urandom_range(63));
			end else if (r < 45) begin
				add_tag(fld, WIRE_FIXED64);
				add_fixed({$urandom, $urandom}, 8);
			end else if (r < 60) begin
				add_tag(fld, WIRE_FIXED32);
				add_fixed(64'($urandom), 4);
			end else if (r < 88) begin
				add_string(fld, ($urandom_range(9) == 0) ? $urandom_range(7, 40)
					: $urandom_range(0, 6));
			end else begin
				case ($urandom_range(4))
				0: add_varint(64'd0);
				1: add_varint({32'($urandom_range(1, 32'hffff_ffff)), 32'($urandom)});
				2: add_tag(fld, pick_bad_wire());
				3: begin
					add_tag(fld, WIRE_VARINT);
					repeat (10)
						msg_bytes.push_back(8'h80 | 8'($urandom));
				end
				default: begin
					add_tag(fld, WIRE_LEN);
					add_varint(64'(MAX_STRING_LEN) + 64'($urandom_range(1, 1000000)));
				end
				endcase
			end
		end
		if ($urandom_range(99) < 15 && msg_bytes.size() > 1) begin
			keep = $urandom_range(1, msg_bytes.size() - 1);
			while (msg_bytes.size() > keep)
				void'(msg_bytes.pop_back());
		end
	endtask

	task automatic test_register_reset_values();
		check_register(ADDR_SIGNED_FIELD_A, SIGNED_A_RESET);
		check_register(ADDR_SIGNED_FIELD_B, SIGNED_B_RESET);
	endtask

	task automatic test_scalar_fields();
		add_scalar(29'd1, 64'd150);
		add_scalar(29'd3, 64'd1);
		add_scalar(29'd2, '1);
		send_message();
		add_scalar(29'd9, '1);
		add_scalar(FIELD_MAX, 64'd0);
		send_message();
		add_tag(29'd4, WIRE_FIXED64);
		add_fixed(64'h8000_0000_0000_00ff, 8);
		add_tag(29'd5, WIRE_FIXED32);
		add_fixed(64'hdead_beef, 4);
		send_message();
	endtask

	task automatic test_string_fields();
		add_tag(29'd0, WIRE_LEN);
		add_varint(64'd3);
		msg_bytes.push_back(8'h00);
		msg_bytes.push_back(8'hff);
		msg_bytes.push_back(8'h7f);
		send_message();
		// empty string followed by another field
		add_string(29'd7, 0);
		add_string(29'd8, 1);
		send_message();
		// largest allowed length, cut after two payload bytes
		add_tag(29'd2, WIRE_LEN);
		add_varint(64'(MAX_STRING_LEN));
		add_run(8'h55, 2);
		send_message();
	endtask

	task automatic test_malformed_input();
		add_varint(64'd0);
		add_scalar(29'd1, 64'd1);
		send_message();
		add_varint(64'h1_0000_0008);
		msg_bytes.push_back(8'h00);
		send_message();
		add_tag(29'd1, WIRE_GROUP_START);
		msg_bytes.push_back(8'h01);
		send_message();
		add_tag(29'd1, WIRE_GROUP_END);
		send_message();
		add_tag(29'd1, WIRE_RESERVED_6);
		msg_bytes.push_back(8'h01);
		send_message();
		add_tag(29'd1, WIRE_RESERVED_7);
		send_message();
		// overlong tag, then trailing byte dropped
		add_run(8'h80, 10);
		msg_bytes.push_back(8'h00);
		send_message();
		// overlong value ending on the byte that overflows: error wins over truncation
		add_tag(29'd1, WIRE_VARINT);
		add_run(8'hff, 10);
		send_message();
		add_tag(29'd2, WIRE_LEN);
		add_varint(64'(MAX_STRING_LEN) + 64'd1);
		send_message();
	endtask

	task automatic test_truncated_messages();
		add_tag(29'd1, WIRE_VARINT);
		send_message();
		add_tag(29'd1, WIRE_VARINT);
		msg_bytes.push_back(8'hff);
		send_message();
		add_tag(29'd4, WIRE_FIXED64);
		add_fixed(64'h0302_01, 3);
		send_message();
		add_tag(29'd5, WIRE_FIXED32);
		msg_bytes.push_back(8'haa);
		send_message();
		add_tag(29'd6, WIRE_LEN);
		send_message();
		// unfinished tag varint still counts as between fields
		msg_bytes.push_back(8'h80);
		send_message();
	endtask

	task automatic test_zigzag_registers();
		set_zigzag_field(ADDR_SIGNED_FIELD_A, 32'd0);
		set_zigzag_field(ADDR_SIGNED_FIELD_B, 32'hffff_ffff);
		add_scalar(FIELD_MAX, 64'd5);
		add_scalar(29'd3, 64'd5);
		add_scalar(29'd9, 64'd6);
		send_message();
		set_zigzag_field(ADDR_SIGNED_FIELD_A, 32'd12);
		set_zigzag_field(ADDR_SIGNED_FIELD_B, 32'd12);
		add_scalar(29'd12, 64'hffff_ffff_ffff_fffe);
		add_scalar(29'd12, 64'd7);
		send_message();
	endtask

	task automatic test_backpressure();
		hold_reqs++;
		add_string(29'd6, 48);
		send_message();
	endtask

	task automatic test_random_traffic(input int unsigned n_bytes);
		int unsigned start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			build_random_message();
			send_message();
		end
	endtask

	initial begin
		zz_field_a = SIGNED_A_RESET;
		zz_field_b = SIGNED_B_RESET;
		clear_parse_state();
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset_values();
		test_scalar_fields();
		test_string_fields();
		test_malformed_input();
		test_truncated_messages();
		test_zigzag_registers();
		set_zigzag_field(ADDR_SIGNED_FIELD_A, 32'(SIGNED_A_RESET));
		set_zigzag_field(ADDR_SIGNED_FIELD_B, 32'(SIGNED_B_RESET));
		test_backpressure();
		test_random_traffic(190);

		// stretch with no idling on either side
		set_zigzag_field(ADDR_SIGNED_FIELD_A, 32'($urandom_range(1, 31)));
		set_zigzag_field(ADDR_SIGNED_FIELD_B, 32'($urandom_range(1, 31)));
		idle_on = 1'b0;
		test_random_traffic(190);
		idle_on = 1'b1;

		set_zigzag_field(ADDR_SIGNED_FIELD_A, 32'hffff_ffff);
		set_zigzag_field(ADDR_SIGNED_FIELD_B, 32'd0);
		test_random_traffic(190);

		while (pending_records.size() != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
